[rtl/csru_pkg.sv]
// Package for the crypto stream reassembly unit: sizes, beat layouts,
// command and state types shared by the front, queue, back and top level.
// No dependencies.
`timescale 1ns / 1ps

package csru_pkg;

    // Reassembly buffer size and derived address width
    localparam int BUFFER_BYTES = 4096;
    localparam int BUF_AW       = $clog2(BUFFER_BYTES);

    // Field widths
    localparam int ACTION_W = 2;
    localparam int OFFSET_W = 62;
    localparam int LEN_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int PREFIX_W = 13;

    // Frame end sum: one bit above the length, wide enough for any address
    localparam int END_W = LEN_W + 1;

    // Input tdata layout, lowest field first
    localparam int LEN_LSB     = OFFSET_W;
    localparam int IDX_LSB     = LEN_LSB + LEN_W;
    localparam int BYTE_LSB    = IDX_LSB + LEN_W;
    localparam int IN_TDATA_W  = ((BYTE_LSB + BYTE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((PREFIX_W + 1 + 7) / 8) * 8;

    // Buffer word: data byte with its filled mark on top
    localparam int WORD_W   = BYTE_W + 1;
    localparam int MARK_BIT = BYTE_W;

    // Command queue between front and back
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PW    = $clog2(CMD_DEPTH);

    typedef enum logic [ACTION_W-1:0] {
        ACT_DATA       = 2'd0,
        ACT_DECODE_ERR = 2'd1,
        ACT_END_PKT    = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        CMD_REPORT,
        CMD_STORE,
        CMD_SCAN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [BUF_AW-1:0]   pos;
        logic [BYTE_W-1:0]   data;
        logic                status;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_RUN,
        BK_SCAN,
        BK_POST
    } back_state_t;

endpackage

[rtl/csru_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module csru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/csru_front.sv]
// Front end: accepts input beats, checks frame bounds, tracks the packet
// failure flag and turns each beat into one command. Uses csru_pkg.
`timescale 1ns / 1ps

module csru_front
    import csru_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [ACTION_W-1:0] action,
    input  logic [OFFSET_W-1:0] frame_offset,
    input  logic [LEN_W-1:0]    frame_length,
    input  logic [LEN_W-1:0]    byte_index,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic                fifo_full,
    input  logic                clear_busy,
    output logic                push,
    output cmd_t                cmd
);

    logic             fail_reg;
    logic             fail_next;
    logic             offset_high;
    logic [END_W-1:0] frame_end;
    logic             overflow;

    assign s_tready = !fifo_full && !clear_busy;
    assign push     = s_tvalid && s_tready;

    // Frame end beyond buffer: any offset bit above the address, or sum too big
    assign offset_high = |frame_offset[OFFSET_W-1:BUF_AW];
    assign frame_end   = END_W'(frame_offset[BUF_AW-1:0]) + END_W'(frame_length);
    assign overflow    = offset_high || (frame_end > END_W'(BUFFER_BYTES));

    always_comb
    begin
        fail_next  = fail_reg;
        cmd.kind   = CMD_REPORT;
        cmd.pos    = frame_offset[BUF_AW-1:0] + byte_index[BUF_AW-1:0];
        cmd.data   = data_byte;
        cmd.status = fail_reg;
        case (action)
            ACT_DATA:
            begin
                if (!fail_reg)
                begin
                    if (overflow)
                    begin
                        fail_next  = 1'b1;
                        cmd.status = 1'b1;
                    end
                    else if (byte_index < frame_length)
                    begin
                        cmd.kind = CMD_STORE;
                    end
                end
            end
            ACT_DECODE_ERR:
            begin
                fail_next  = 1'b1;
                cmd.status = 1'b1;
            end
            ACT_END_PKT:
            begin
                // status reports the packet just ended; flag clears for the next
                if (!fail_reg)
                begin
                    cmd.kind = CMD_SCAN;
                end
                fail_next = 1'b0;
            end
            default:
            begin
                fail_next = fail_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_reg <= 1'b0;
        end
        else if (push)
        begin
            fail_reg <= fail_next;
        end
    end

endmodule

[rtl/csru_fifo.sv]
// Short command queue between front and back end.
// Uses csru_pkg.
`timescale 1ns / 1ps

module csru_fifo
    import csru_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic full,
    output logic empty
);

    cmd_t              entries_reg [CMD_DEPTH];
    logic [CMD_PW-1:0] wr_ptr_reg;
    logic [CMD_PW-1:0] rd_ptr_reg;
    logic [CMD_PW:0]   count_reg;
    logic [CMD_PW:0]   count_next;

    assign full     = (count_reg == (CMD_PW + 1)'(CMD_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

[rtl/csru_back.sv]
// Back end: clears the buffer after reset, writes stored bytes, walks the
// filled marks at end of packet and drives the result register.
// Uses csru_pkg and csru_ram.
`timescale 1ns / 1ps

module csru_back
    import csru_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fifo_empty,
    input  cmd_t                head_cmd,
    output logic                pop,
    output logic                clear_busy,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [PREFIX_W-1:0] contiguous_prefix,
    output logic                packet_status
);

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [BUF_AW-1:0]   clr_addr_reg;
    logic [BUF_AW-1:0]   clr_addr_next;
    logic [PREFIX_W-1:0] prefix_reg;
    logic [PREFIX_W-1:0] prefix_next;
    logic [PREFIX_W-1:0] prefix_inc;
    logic                prefix_full;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [PREFIX_W-1:0] out_prefix_reg;
    logic [PREFIX_W-1:0] out_prefix_next;
    logic                out_status_reg;
    logic                out_status_next;
    logic                out_free;
    logic                ram_we;
    logic [BUF_AW-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [BUF_AW-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    csru_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BUFFER_BYTES)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free          = !out_valid_reg || m_tready;
    assign prefix_inc        = prefix_reg + 1'b1;
    assign prefix_full       = (prefix_reg == PREFIX_W'(BUFFER_BYTES));
    assign clear_busy        = (state_reg == BK_CLEAR);
    assign m_tvalid          = out_valid_reg;
    assign contiguous_prefix = out_prefix_reg;
    assign packet_status     = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        prefix_next     = prefix_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_prefix_next = out_prefix_reg;
        out_status_next = out_status_reg;
        pop             = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = clr_addr_reg;
        ram_wdata       = '0;
        ram_raddr       = prefix_reg[BUF_AW-1:0];
        case (state_reg)
            BK_CLEAR:
            begin
                ram_we = 1'b1;
                if (clr_addr_reg == '1)
                begin
                    state_next = BK_RUN;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            BK_RUN:
            begin
                if (!fifo_empty)
                begin
                    case (head_cmd.kind)
                        CMD_SCAN:
                        begin
                            // read of the mark at prefix_reg is issued here
                            pop        = 1'b1;
                            state_next = prefix_full ? BK_POST : BK_SCAN;
                        end
                        CMD_STORE:
                        begin
                            if (out_free)
                            begin
                                pop             = 1'b1;
                                ram_we          = 1'b1;
                                ram_waddr       = head_cmd.pos;
                                ram_wdata       = {1'b1, head_cmd.data};
                                out_valid_next  = 1'b1;
                                out_prefix_next = prefix_reg;
                                out_status_next = head_cmd.status;
                            end
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                pop             = 1'b1;
                                out_valid_next  = 1'b1;
                                out_prefix_next = prefix_reg;
                                out_status_next = head_cmd.status;
                            end
                        end
                    endcase
                end
            end
            BK_SCAN:
            begin
                // one mark per cycle: next address read while this one is checked
                if (ram_rdata[MARK_BIT])
                begin
                    prefix_next = prefix_inc;
                    ram_raddr   = prefix_inc[BUF_AW-1:0];
                    if (prefix_inc == PREFIX_W'(BUFFER_BYTES))
                    begin
                        state_next = BK_POST;
                    end
                end
                else
                begin
                    state_next = BK_POST;
                end
            end
            BK_POST:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_prefix_next = prefix_reg;
                    out_status_next = 1'b0;
                    state_next      = BK_RUN;
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_addr_reg  <= '0;
            prefix_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            prefix_reg    <= prefix_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_prefix_reg <= out_prefix_next;
        out_status_reg <= out_status_next;
    end

`ifndef SYNTHESIS
    a_prefix_bound: assert property (@(posedge clk) disable iff (!rst_n)
        prefix_reg <= PREFIX_W'(BUFFER_BYTES))
        else $error("prefix beyond buffer");

    a_prefix_moves_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_SCAN) |=> $stable(prefix_reg))
        else $error("prefix changed outside scan");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SCAN) |-> !ram_we)
        else $error("buffer write during scan");

    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_CLEAR) |-> !pop)
        else $error("command taken during clear");
`endif

endmodule

[rtl/crypto_stream_reassembly_unit.sv]
// Top level of the crypto stream reassembly unit: unpacks beats, ties the
// front end, command queue and back end together. Uses csru_pkg and all csru_* modules.
//
// Channel | Dir | Signals                    | Content
// --------+-----+----------------------------+-----------------------------------------
// s_      | in  | tvalid tready tdata tuser  | tuser: action; tdata: offset/len/idx/byte
// m_      | out | tvalid tready tdata        | tdata: contiguous_prefix, packet_status
//
// Cycles: data, decode-error and unused-action beats take one cycle each in the
// back end, so they stream at one beat per cycle. An end-of-packet beat of a good
// packet takes one cycle to issue the first mark read, walks the filled marks at
// one mark per cycle plus one cycle for the unset mark that stops the walk, then
// one cycle to post the result: 3 + (marks advanced) cycles, one fewer when the
// walk stops at the buffer end.
// Reset: after rst_n rises the back end clears all BUFFER_BYTES filled marks,
// one per cycle (4096 cycles); s_tready stays low until it is done.
// Stalls: a four-entry command queue lets the front keep taking beats while the
// back end scans or m_tready is low; the result register frees both sides.
`timescale 1ns / 1ps

module crypto_stream_reassembly_unit
    import csru_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [61:0] frame_offset, [77:62] frame_length, [93:78] byte_index,
    // [101:94] data_byte, [103:102] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [1:0] action
    input  logic [ACTION_W-1:0]    s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [12:0] contiguous_prefix, [13] packet_status, [15:14] zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    cmd_t                push_cmd;
    cmd_t                head_cmd;
    logic                push;
    logic                pop;
    logic                fifo_full;
    logic                fifo_empty;
    logic                clear_busy;
    logic [PREFIX_W-1:0] contiguous_prefix;
    logic                packet_status;

    // Front: bounds check and packet failure tracking
    csru_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .action       (s_tuser),
        .frame_offset (s_tdata[OFFSET_W-1:0]),
        .frame_length (s_tdata[LEN_LSB +: LEN_W]),
        .byte_index   (s_tdata[IDX_LSB +: LEN_W]),
        .data_byte    (s_tdata[BYTE_LSB +: BYTE_W]),
        .fifo_full    (fifo_full),
        .clear_busy   (clear_busy),
        .push         (push),
        .cmd          (push_cmd)
    );

    // Queue decouples beat intake from mark scanning
    csru_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    // Back: buffer writes, prefix walk, result register
    csru_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .fifo_empty        (fifo_empty),
        .head_cmd          (head_cmd),
        .pop               (pop),
        .clear_busy        (clear_busy),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .contiguous_prefix (contiguous_prefix),
        .packet_status     (packet_status)
    );

    assign m_tdata = OUT_TDATA_W'({packet_status, contiguous_prefix});

endmodule

[sim/csru_stream_checker.sv]
// Scoreboard for the crypto stream reassembly unit: watches both stream channels,
// predicts each result from the accepted input beats and compares. Uses csru_pkg.
`timescale 1ns / 1ps

module csru_stream_checker
    import csru_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [ACTION_W-1:0]    s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     mismatches,
    output int                     outcomes_pending
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [PREFIX_W-1:0] prefix;
        logic                rejected;
    } outcome_t;

    // Shadow of the block state; stored bytes are never read back, so only
    // the marks are kept.
    logic [BUFFER_BYTES-1:0] filled_map;
    logic [PREFIX_W-1:0]     prefix_len;
    logic                    pkt_failed;
    outcome_t                expected_outcomes[$];

    function automatic outcome_t reassemble(
        input logic [ACTION_W-1:0] act,
        input logic [OFFSET_W-1:0] off,
        input logic [LEN_W-1:0]    len,
        input logic [LEN_W-1:0]    idx
    );
        logic [63:0] frame_end;
        logic [63:0] pos;
        outcome_t    res;
        frame_end = 64'(off) + 64'(len);
        pos       = 64'(off) + 64'(idx);
        case (act)
            ACT_DATA:
            begin
                if (!pkt_failed)
                begin
                    // overflow check wins over the index check
                    if (frame_end > 64'(BUFFER_BYTES))
                        pkt_failed = 1'b1;
                    else if (idx < len)
                        filled_map[pos[BUF_AW-1:0]] = 1'b1;
                end
                res.rejected = pkt_failed;
            end
            ACT_DECODE_ERR:
            begin
                pkt_failed   = 1'b1;
                res.rejected = 1'b1;
            end
            ACT_END_PKT:
            begin
                res.rejected = pkt_failed;
                if (!pkt_failed)
                    while (int'(prefix_len) < BUFFER_BYTES &&
                           filled_map[prefix_len[BUF_AW-1:0]])
                        prefix_len++;
                pkt_failed = 1'b0;
            end
            default:
                res.rejected = pkt_failed;
        endcase
        res.prefix = prefix_len;
        return res;
    endfunction

    // Predict before compare: a beat taken at this edge can never be the
    // result leaving at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t seen;
        outcome_t want;
        if (!rst_n)
        begin
            filled_map = '0;
            prefix_len = '0;
            pkt_failed = 1'b0;
            expected_outcomes.delete();
            mismatches       = 0;
            outcomes_pending = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_outcomes.push_back(reassemble(s_tuser,
                                                       s_tdata[OFFSET_W-1:0],
                                                       s_tdata[LEN_LSB +: LEN_W],
                                                       s_tdata[IDX_LSB +: LEN_W]));
            if (m_tvalid && m_tready)
            begin
                seen.prefix   = m_tdata[PREFIX_W-1:0];
                seen.rejected = m_tdata[PREFIX_W];
                if (expected_outcomes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%t: unexpected result beat prefix=%0d status=%0b",
                                 $realtime, seen.prefix, seen.rejected);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%t: result mismatch prefix exp=%0d got=%0d, status exp=%0b got=%0b",
                                     $realtime, want.prefix, seen.prefix,
                                     want.rejected, seen.rejected);
                    end
                end
            end
            outcomes_pending = expected_outcomes.size();
        end
    end

endmodule

[sim/tb_crypto_stream_reassembly_unit.sv]
// Testbench top for the crypto stream reassembly unit: clock, reset, beat
// stimulus and verdict. Needs csru_pkg, the RTL and csru_stream_checker.
`timescale 1ns / 1ps

module tb_crypto_stream_reassembly_unit;
    import csru_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;  // unused action code
    localparam int RANDOM_BEATS   = 900;
    localparam int CLOSE_BYTES    = 64;    // frame size in the closing stretch
    localparam int SQUEEZE_AT     = 60;    // beats sent before the long sink stall
    localparam int SQUEEZE_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 50;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [ACTION_W-1:0]    s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int mismatches;
    int outcomes_pending;
    int beats_sent;
    bit gaps_on;   // source idles between beats
    bit quiet;     // closing stretch: no idling on either side

    crypto_stream_reassembly_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    csru_stream_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .mismatches       (mismatches),
        .outcomes_pending (outcomes_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: covers the clear after reset, long prefix walks and worst-case
    // idling many times over.
    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [OFFSET_W-1:0] any_offset();
        return OFFSET_W'({$urandom, $urandom});
    endfunction

    // Offer one beat and hold it until taken. tvalid stays high between
    // back-to-back beats; it only drops when a gap is inserted.
    task automatic send_beat(
        input logic [ACTION_W-1:0] act,
        input logic [OFFSET_W-1:0] off,
        input logic [LEN_W-1:0]    len,
        input logic [LEN_W-1:0]    idx,
        input logic [BYTE_W-1:0]   val
    );
        if (gaps_on && !quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= IN_TDATA_W'({val, idx, len, off});
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        beats_sent++;
    endtask

    task automatic send_end_of_packet();
        send_beat(ACT_END_PKT, any_offset(), LEN_W'($urandom), LEN_W'($urandom),
                  BYTE_W'($urandom));
    endtask

    // All bytes of one frame in shuffled order; sparse drops some to leave holes.
    task automatic send_frame(input int off, input int flen, input bit sparse);
        int order[$];
        int j;
        int k;
        int tmp;
        for (j = 0; j < flen; j++)
            order.push_back(j);
        for (j = flen - 1; j > 0; j--)
        begin
            k        = $urandom_range(0, j);
            tmp      = order[j];
            order[j] = order[k];
            order[k] = tmp;
        end
        foreach (order[n])
            if (!sparse || $urandom_range(0, 3) != 0)
                send_beat(ACT_DATA, OFFSET_W'(off), LEN_W'(flen), LEN_W'(order[n]),
                          BYTE_W'($urandom));
    endtask

    // Mostly well-formed frames near the growing prefix; the rest is
    // overflow, out-of-frame indices, decode errors and unused actions.
    task automatic send_random_packet(inout int frontier);
        int n_frames;
        int pick;
        int foff;
        int flen;
        int idx;
        n_frames = $urandom_range(1, 4);
        repeat (n_frames)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 82)
            begin
                flen = $urandom_range(1, 16);
                foff = frontier;
                if ($urandom_range(0, 2) == 0)
                    foff += $urandom_range(1, 40);
                if (foff + flen > BUFFER_BYTES)
                    foff = BUFFER_BYTES - flen;
                send_frame(foff, flen, $urandom_range(0, 4) == 0);
                if (foff == frontier)
                    frontier += flen;
            end
            else if (pick < 86)
            begin
                // wild offset: almost always past the buffer
                send_beat(ACT_DATA, any_offset(), LEN_W'($urandom), LEN_W'($urandom),
                          BYTE_W'($urandom));
            end
            else if (pick < 90)
            begin
                // straddles the buffer end, may or may not fit
                foff = BUFFER_BYTES - $urandom_range(1, 16);
                flen = $urandom_range(1, 40);
                idx  = $urandom_range(0, flen - 1);
                send_beat(ACT_DATA, OFFSET_W'(foff), LEN_W'(flen), LEN_W'(idx),
                          BYTE_W'($urandom));
            end
            else if (pick < 94)
            begin
                // index at or past the frame length: ignored, no failure
                flen = $urandom_range(0, 16);
                idx  = $urandom_range(flen, 65535);
                foff = (frontier + flen <= BUFFER_BYTES) ? frontier : 0;
                send_beat(ACT_DATA, OFFSET_W'(foff), LEN_W'(flen), LEN_W'(idx),
                          BYTE_W'($urandom));
            end
            else if (pick < 97)
                send_beat(ACT_DECODE_ERR, any_offset(), LEN_W'($urandom),
                          LEN_W'($urandom), BYTE_W'($urandom));
            else
                send_beat(ACT_NOP, any_offset(), LEN_W'($urandom), LEN_W'($urandom),
                          BYTE_W'($urandom));
        end
        send_end_of_packet();
    endtask

    // Result sink: random stall bursts in windows that switch stalling on
    // and off, one long hold-off early on to back the block up into the
    // source, and no stalls at all in the closing stretch.
    initial
    begin : result_sink
        int  stall_left;
        int  window_left;
        bit  stalls_on;
        bit  squeezed;
        stall_left  = 0;
        window_left = 0;
        stalls_on   = 1'b1;
        squeezed    = 1'b0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (window_left == 0)
            begin
                window_left = 150;
                stalls_on   = ($urandom_range(0, 2) != 0);
            end
            window_left--;
            if (!squeezed && beats_sent >= SQUEEZE_AT)
            begin
                squeezed   = 1'b1;
                stall_left = SQUEEZE_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && stalls_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 10);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int frontier;
        int start_beats;
        int close_off;
        frontier   = 0;
        beats_sent = 0;
        gaps_on    = 1'b1;
        quiet      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ACT_DATA;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part
        send_end_of_packet();                                   // empty packet
        send_beat(ACT_DATA, '0, 16'd2, 16'd1, 8'hFF);           // out of order
        send_beat(ACT_DATA, '0, 16'd2, 16'd0, 8'h00);
        send_end_of_packet();                                   // prefix to 2
        send_beat(ACT_DATA, 62'd10, 16'd3, 16'd3, 8'h5A);       // index == length
        send_beat(ACT_DATA, '0, 16'd0, 16'd0, 8'h11);           // empty frame
        send_beat(ACT_DATA, 62'd4094, 16'd2, 16'd1, 8'hA5);     // ends at buffer end
        send_beat(ACT_DATA, 62'd4095, 16'd1, 16'd0, 8'h3C);
        send_end_of_packet();
        send_beat(ACT_DATA, 62'd4095, 16'd2, 16'd0, 8'h77);     // one byte past end
        send_beat(ACT_DATA, 62'd2, 16'd1, 16'd0, 8'h99);        // dropped, packet failed
        send_end_of_packet();                                   // rejected
        send_beat(ACT_DATA, {OFFSET_W{1'b1}}, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_end_of_packet();
        send_beat(ACT_DATA, 62'd2, 16'd1, 16'd0, 8'h42);        // stored, then failed
        send_beat(ACT_DECODE_ERR, '0, '0, '0, '0);
        send_beat(ACT_DATA, 62'd3, 16'd1, 16'd0, 8'h43);        // ignored
        send_end_of_packet();                                   // prefix must hold
        send_beat(ACT_NOP, {OFFSET_W{1'b1}}, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_end_of_packet();                                   // picks up byte 2
        send_beat(ACT_DATA, '0, 16'hFFFF, 16'd0, 8'h01);        // huge length overflows
        send_end_of_packet();
        frontier = 3;

        // Random part
        start_beats = beats_sent;
        while (beats_sent - start_beats < RANDOM_BEATS)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            send_random_packet(frontier);
        end

        // Closing stretch without idling: one full frame at the frontier (or ending at
        // the buffer end when it does not fit), then a byte at the buffer end.
        quiet   = 1'b1;
        gaps_on = 1'b0;
        close_off = (frontier + CLOSE_BYTES <= BUFFER_BYTES) ? frontier
                                                             : BUFFER_BYTES - CLOSE_BYTES;
        send_frame(close_off, CLOSE_BYTES, 1'b0);
        send_end_of_packet();
        send_beat(ACT_DATA, 62'd4095, 16'd1, 16'd0, 8'hEE);
        send_end_of_packet();
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (outcomes_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outcomes_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
